@@ src/sed_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

	localparam logic [3:0] MAX_HEX_DIGITS = 4'd8;
	localparam int NUM_PEND = 7;

	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_N   = 8'h6E;
	localparam logic [7:0] CH_T   = 8'h74;
	localparam logic [7:0] CH_R   = 8'h72;
	localparam logic [7:0] CH_A   = 8'h61;
	localparam logic [7:0] CH_B   = 8'h62;
	localparam logic [7:0] CH_F   = 8'h66;
	localparam logic [7:0] CH_V   = 8'h76;
	localparam logic [7:0] CH_X   = 8'h78;
	localparam logic [7:0] CH_LU  = 8'h75;
	localparam logic [7:0] CH_UU  = 8'h55;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF  = 8'h66;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;

	localparam logic [7:0] BY_LF  = 8'h0A;
	localparam logic [7:0] BY_TAB = 8'h09;
	localparam logic [7:0] BY_CR  = 8'h0D;
	localparam logic [7:0] BY_BEL = 8'h07;
	localparam logic [7:0] BY_BS  = 8'h08;
	localparam logic [7:0] BY_FF  = 8'h0C;
	localparam logic [7:0] BY_VT  = 8'h0B;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_UTF8,
		CMD_FLUSH
	} cmd_kind_t;

	typedef logic [NUM_PEND-1:0][7:0] digits_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  byte_v;
		logic [7:0]  letter;
		digits_t     digits;
		logic        tail;
		logic [3:0]  cnt;
		logic [20:0] cp;
		logic        last;
	} cmd_t;

	// {valid, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= CH_0 && c <= CH_9) begin
			r = {1'b1, 4'(c - CH_0)};
		end else if (c >= CH_LA && c <= CH_LF) begin
			r = {1'b1, 4'(c - CH_LA + 8'd10)};
		end else if (c >= CH_UA && c <= CH_UF) begin
			r = {1'b1, 4'(c - CH_UA + 8'd10)};
		end
		return r;
	endfunction

	function automatic logic [3:0] clamp_digits(input logic [3:0] n);
		return (n > MAX_HEX_DIGITS) ? MAX_HEX_DIGITS : n;
	endfunction

	function automatic logic [3:0] utf8_len(input logic [31:0] cp);
		logic [3:0] r;
		if (cp <= 32'h7F) begin
			r = 4'd1;
		end else if (cp <= 32'h7FF) begin
			r = 4'd2;
		end else if (cp <= 32'hFFFF) begin
			r = 4'd3;
		end else begin
			r = 4'd4;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/string_escape_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Decodes the inner bytes of a quoted string, one byte per input beat.
// s_tuser high selects escape decoding (\n \t \r \a \b \f \v, \xHH,
// \uHHHH, \UHHHHHHHH as UTF-8); low passes bytes through. s_tlast marks the
// final byte of the string. An input beat yields zero to nine output beats;
// m_tuser marks the last output beat of each input beat and m_tlast the
// last output beat of the string. The front decoder takes one input beat
// per cycle while the two-entry command queue has room; the back end emits
// one output byte per cycle while the output is not stalled, and a burst of
// multi-byte results throttles input once the queue fills.
module string_escape_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic        s_tlast,
	input  logic        s_tuser,   // [0] escapes_on
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,
	output logic        m_tuser    // [0] run_last
);
	import sed_pkg::*;

	cmd_t cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	sed_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.char_byte  (s_tdata),
		.last_char  (s_tlast),
		.escapes_on (s_tuser),
		.q_full     (q_full),
		.push       (push),
		.cmd        (cmd)
	);

	sed_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (cmd),
		.pop     (pop),
		.rd_data (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	sed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.run_last   (m_tuser),
		.string_end (m_tlast)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full)) else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_empty)) else $error("command queue underflow");

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser) else $error("string end inside a run");

	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cmd.cnt != 4'd0 && cmd.cnt <= 4'd9)) else $error("bad result count");
`endif

endmodule

`default_nettype wire

@@ src/sed_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sed_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   char_byte,
	input  logic         last_char,
	input  logic         escapes_on,
	input  logic         q_full,
	output logic         push,
	output sed_pkg::cmd_t cmd
);
	import sed_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_BSL  = 3'b010,
		PH_HEX  = 3'b100
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  letter_q, letter_d;
	logic [3:0]  wanted_q, wanted_d;
	logic [2:0]  seen_q, seen_d;
	logic [31:0] acc_q, acc_d;
	digits_t     pend_q;
	logic        pend_we;
	logic        gen;
	logic        accept;
	logic [4:0]  hx;
	logic [31:0] acc_n;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && gen;
	assign hx       = hex_decode(char_byte);
	assign acc_n    = {acc_q[27:0], hx[3:0]};

	always_comb begin
		phase_d    = phase_q;
		letter_d   = letter_q;
		wanted_d   = wanted_q;
		seen_d     = seen_q;
		acc_d      = acc_q;
		pend_we    = 1'b0;
		gen        = 1'b0;
		cmd.kind   = CMD_BYTE;
		cmd.byte_v = char_byte;
		cmd.letter = letter_q;
		cmd.digits = pend_q;
		cmd.tail   = 1'b0;
		cmd.cnt    = 4'd1;
		cmd.cp     = acc_n[20:0];
		cmd.last   = last_char;
		case (phase_q)
			PH_BSL: begin
				phase_d = PH_IDLE;
				gen     = 1'b1;
				case (char_byte)
					CH_N: cmd.byte_v = BY_LF;
					CH_T: cmd.byte_v = BY_TAB;
					CH_R: cmd.byte_v = BY_CR;
					CH_A: cmd.byte_v = BY_BEL;
					CH_B: cmd.byte_v = BY_BS;
					CH_F: cmd.byte_v = BY_FF;
					CH_V: cmd.byte_v = BY_VT;
					CH_X, CH_LU, CH_UU: begin
						if (!last_char) begin
							gen      = 1'b0;
							letter_d = char_byte;
							seen_d   = '0;
							acc_d    = '0;
							phase_d  = PH_HEX;
							if (char_byte == CH_X) begin
								wanted_d = clamp_digits(4'd2);
							end else if (char_byte == CH_LU) begin
								wanted_d = clamp_digits(4'd4);
							end else begin
								wanted_d = clamp_digits(4'd8);
							end
						end
					end
					default: cmd.byte_v = char_byte;
				endcase
			end
			PH_HEX: begin
				if (hx[4]) begin
					acc_d = acc_n;
					if (({1'b0, seen_q} + 4'd1) >= wanted_q) begin
						gen     = 1'b1;
						phase_d = PH_IDLE;
						seen_d  = '0;
						if (letter_q == CH_X) begin
							cmd.byte_v = acc_n[7:0];
						end else begin
							cmd.kind = CMD_UTF8;
							cmd.cnt  = utf8_len(acc_n);
						end
					end else if (last_char) begin
						gen      = 1'b1;
						phase_d  = PH_IDLE;
						seen_d   = '0;
						cmd.kind = CMD_FLUSH;
						cmd.tail = 1'b1;
						cmd.cnt  = {1'b0, seen_q} + 4'd2;
					end else begin
						pend_we = 1'b1;
						seen_d  = seen_q + 3'd1;
					end
				end else begin
					gen      = 1'b1;
					phase_d  = PH_IDLE;
					seen_d   = '0;
					cmd.kind = CMD_FLUSH;
					if (escapes_on && char_byte == CH_BSL && !last_char) begin
						phase_d = PH_BSL;
						cmd.cnt = {1'b0, seen_q} + 4'd1;
					end else begin
						cmd.tail = 1'b1;
						cmd.cnt  = {1'b0, seen_q} + 4'd2;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (escapes_on && char_byte == CH_BSL && !last_char) begin
					phase_d = PH_BSL;
				end else begin
					gen = 1'b1;
				end
			end
		endcase
		if (last_char) begin
			phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			letter_q <= '0;
			wanted_q <= '0;
			seen_q   <= '0;
			acc_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			letter_q <= letter_d;
			wanted_q <= wanted_d;
			seen_q   <= seen_d;
			acc_q    <= acc_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_PEND; i++) begin
			if (accept && pend_we && seen_q == 3'(i)) begin
				pend_q[i] <= char_byte;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/sed_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sed_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sed_pkg::cmd_t wr_data,
	input  logic          pop,
	output sed_pkg::cmd_t rd_data,
	output logic          full,
	output logic          empty
);
	import sed_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

@@ src/sed_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sed_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  sed_pkg::cmd_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          run_last,
	output logic          string_end
);
	import sed_pkg::*;

	logic [3:0] idx_q;
	logic       ov_q;
	logic       step;
	logic       fin;
	logic [7:0] sel;
	logic [7:0] lead;
	logic [1:0] sh;
	logic [5:0] six;
	logic [2:0] dsel;

	assign step      = !q_empty && (!ov_q || out_ready);
	assign fin       = idx_q == (head.cnt - 4'd1);
	assign pop       = step && fin;
	assign out_valid = ov_q;
	assign sh        = 2'(head.cnt - 4'd1 - idx_q);
	assign dsel      = 3'(idx_q - 4'd1);

	always_comb begin
		case (head.cnt)
			4'd1:    lead = {1'b0, head.cp[6:0]};
			4'd2:    lead = {3'b110, head.cp[10:6]};
			4'd3:    lead = {4'b1110, head.cp[15:12]};
			default: lead = {5'b11110, head.cp[20:18]};
		endcase
		case (sh)
			2'd0:    six = head.cp[5:0];
			2'd1:    six = head.cp[11:6];
			default: six = head.cp[17:12];
		endcase
		case (head.kind)
			CMD_UTF8: begin
				sel = (idx_q == 4'd0) ? lead : {2'b10, six};
			end
			CMD_FLUSH: begin
				if (idx_q == 4'd0) begin
					sel = head.letter;
				end else if (head.tail && fin) begin
					sel = head.byte_v;
				end else begin
					sel = head.digits[dsel];
				end
			end
			default: sel = head.byte_v;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ov_q  <= 1'b0;
		end else if (step) begin
			idx_q <= fin ? 4'd0 : idx_q + 4'd1;
			ov_q  <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte   <= sel;
			run_last   <= fin;
			string_end <= fin && head.last;
		end
	end

endmodule

`default_nettype wire

@@ sim/string_escape_decoder_core_tb.sv @@
`timescale 1ns / 1ps

module string_escape_decoder_core_tb;
	import sed_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_BSL,
		PH_HEX
	} dec_phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       esc;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       str_end;
	} out_sym_t;

	localparam int IDLE_PCT = 38;
	localparam int RAND_BEATS = 440;
	localparam int RX_HOLD_AT = 120;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int CALM_FROM = 300;
	localparam int CALM_TO = 380;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;
	logic       s_tlast = 1'b0;
	logic       s_tuser = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	in_beat_t feed_q[$];
	out_sym_t decoded_q[$];
	in_beat_t drv_beat;
	out_sym_t exp_sym;
	int       acc_cnt = 0;
	int       err_cnt = 0;
	int       rx_hold_left = 0;
	logic     rx_hold_done = 1'b0;
	logic     calm;
	int       rand_beats;

	// decoder state
	dec_phase_t dec_phase = PH_IDLE;
	logic [7:0] dec_letter = '0;
	logic [3:0] dec_want = '0;
	logic [2:0] dec_seen = '0;
	logic [31:0] dec_acc = '0;
	logic [7:0] dec_pend [0:7];

	logic [7:0] simple_set [0:7] = '{CH_N, CH_T, CH_R, CH_A, CH_B, CH_F, CH_V, CH_BSL};

	string_escape_decoder_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	assign calm = (acc_cnt >= CALM_FROM) && (acc_cnt < CALM_TO);

	function automatic int hex_nib(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return int'(c - CH_0);
		if (c >= CH_LA && c <= CH_LF)
			return int'(c - CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF)
			return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return CH_0 + 8'(v);
		return ($urandom_range(1) ? CH_UA : CH_LA) + 8'(v) - 8'd10;
	endfunction

	task automatic decode_beat(input logic [7:0] c, input logic last, input logic esc);
		logic [7:0] obytes[$];
		logic       to_idle;
		logic [3:0] want;
		int         nib;
		int         i;
		out_sym_t   sym;
		to_idle = 1'b0;
		case (dec_phase)
			PH_BSL: begin
				dec_phase = PH_IDLE;
				case (c)
					CH_N: obytes.insert(obytes.size(), BY_LF);
					CH_T: obytes.insert(obytes.size(), BY_TAB);
					CH_R: obytes.insert(obytes.size(), BY_CR);
					CH_A: obytes.insert(obytes.size(), BY_BEL);
					CH_B: obytes.insert(obytes.size(), BY_BS);
					CH_F: obytes.insert(obytes.size(), BY_FF);
					CH_V: obytes.insert(obytes.size(), BY_VT);
					CH_X, CH_LU, CH_UU: begin
						if (last) begin
							obytes.insert(obytes.size(), c);
						end else begin
							want = (c == CH_X) ? 4'd2 : ((c == CH_LU) ? 4'd4 : 4'd8);
							dec_letter = c;
							dec_want = (want > MAX_HEX_DIGITS) ? MAX_HEX_DIGITS : want;
							dec_seen = '0;
							dec_acc = '0;
							dec_phase = PH_HEX;
						end
					end
					default: obytes.insert(obytes.size(), c);
				endcase
			end
			PH_HEX: begin
				nib = hex_nib(c);
				if (nib >= 0)
					dec_acc = {dec_acc[27:0], 4'(nib)};
				if (nib >= 0 && dec_seen + 4'd1 >= dec_want) begin
					if (dec_letter == CH_X) begin
						obytes.insert(obytes.size(), dec_acc[7:0]);
					end else if (dec_acc <= 32'h7F) begin
						obytes.insert(obytes.size(), dec_acc[7:0]);
					end else if (dec_acc <= 32'h7FF) begin
						obytes.insert(obytes.size(), {3'b110, dec_acc[10:6]});
						obytes.insert(obytes.size(), {2'b10, dec_acc[5:0]});
					end else if (dec_acc <= 32'hFFFF) begin
						obytes.insert(obytes.size(), {4'b1110, dec_acc[15:12]});
						obytes.insert(obytes.size(), {2'b10, dec_acc[11:6]});
						obytes.insert(obytes.size(), {2'b10, dec_acc[5:0]});
					end else begin
						obytes.insert(obytes.size(), {5'b11110, dec_acc[20:18]});
						obytes.insert(obytes.size(), {2'b10, dec_acc[17:12]});
						obytes.insert(obytes.size(), {2'b10, dec_acc[11:6]});
						obytes.insert(obytes.size(), {2'b10, dec_acc[5:0]});
					end
					dec_phase = PH_IDLE;
					dec_seen = '0;
				end else if (nib >= 0 && !last) begin
					dec_pend[dec_seen] = c;
					dec_seen = dec_seen + 3'd1;
				end else begin
					// broken or cut short: letter and buffered digits go out as text
					obytes.insert(obytes.size(), dec_letter);
					for (i = 0; i < dec_seen; i++)
						obytes.insert(obytes.size(), dec_pend[i]);
					dec_phase = PH_IDLE;
					dec_seen = '0;
					to_idle = 1'b1;
				end
			end
			default: to_idle = 1'b1;
		endcase
		if (to_idle) begin
			if (esc && c == CH_BSL && !last)
				dec_phase = PH_BSL;
			else
				obytes.insert(obytes.size(), c);
		end
		if (last)
			dec_phase = PH_IDLE;
		for (i = 0; i < obytes.size(); i++) begin
			sym.data = obytes[i];
			sym.run_last = (i == obytes.size() - 1);
			sym.str_end = sym.run_last && last;
			decoded_q.insert(decoded_q.size(), sym);
		end
	endtask

	task automatic add_beat(input logic [7:0] c, input logic last, input logic esc);
		in_beat_t b;
		b.ch = c;
		b.last = last;
		b.esc = esc;
		feed_q.insert(feed_q.size(), b);
	endtask

	task automatic add_string();
		logic [7:0]  txt[$];
		logic [7:0]  letter;
		logic [31:0] v;
		logic        esc;
		int          ntok;
		int          k;
		int          kind;
		int          nd;
		int          j;
		esc = ($urandom_range(99) < 80);
		ntok = $urandom_range(1, 6);
		for (k = 0; k < ntok; k++) begin
			kind = $urandom_range(9);
			if (kind < 3) begin
				txt.insert(txt.size(), 8'($urandom_range(255)));
			end else if (kind < 5) begin
				txt.insert(txt.size(), CH_BSL);
				if ($urandom_range(3) == 0)
					txt.insert(txt.size(), 8'($urandom_range(255)));
				else
					txt.insert(txt.size(), simple_set[$urandom_range(7)]);
			end else begin
				txt.insert(txt.size(), CH_BSL);
				case ($urandom_range(2))
					0: begin
						letter = CH_X;
						nd = 2;
						v = $urandom_range(255);
					end
					1: begin
						letter = CH_LU;
						nd = 4;
						case ($urandom_range(2))
							0: v = $urandom_range(32'h7F);
							1: v = $urandom_range(32'h7FF, 32'h80);
							default: v = $urandom_range(32'hFFFF, 32'h800);
						endcase
					end
					default: begin
						letter = CH_UU;
						nd = 8;
						case ($urandom_range(2))
							0: v = $urandom_range(32'hFFFF);
							1: v = $urandom_range(32'h1FFFFF, 32'h10000);
							default: v = $urandom;
						endcase
					end
				endcase
				txt.insert(txt.size(), letter);
				for (j = nd - 1; j >= 0; j--)
					txt.insert(txt.size(), hex_char(4'(v >> (4 * j))));
				case ($urandom_range(9))
					0: repeat ($urandom_range(1, nd - 1)) txt.delete(txt.size() - 1);
					1: txt[txt.size() - 1 - $urandom_range(nd - 1)] = 8'($urandom_range(255));
					default: ;
				endcase
			end
		end
		for (k = 0; k < txt.size(); k++) begin
			if ($urandom_range(19) == 0)
				esc = ~esc;
			add_beat(txt[k], k == txt.size() - 1, esc);
		end
		rand_beats += txt.size();
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			s_tuser <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (feed_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				drv_beat = feed_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= drv_beat.ch;
				s_tlast <= drv_beat.last;
				s_tuser <= drv_beat.esc;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold_left <= 0;
			rx_hold_done <= 1'b0;
		end else if (rx_hold_left != 0) begin
			m_tready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else if (!rx_hold_done && acc_cnt >= RX_HOLD_AT) begin
			m_tready <= 1'b0;
			rx_hold_left <= RX_HOLD_CYCLES;
			rx_hold_done <= 1'b1;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// monitor: predict on input beats, check output beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_beat(s_tdata, s_tlast, s_tuser);
				acc_cnt <= acc_cnt + 1;
			end
			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t unexpected beat: expected none actual %h", $time, m_tdata);
					err_cnt++;
				end else begin
					exp_sym = decoded_q.pop_front();
					if (m_tdata !== exp_sym.data) begin
						$display("%0t out_byte mismatch: expected %h actual %h",
							$time, exp_sym.data, m_tdata);
						err_cnt++;
					end
					if (m_tuser !== exp_sym.run_last) begin
						$display("%0t run_last mismatch: expected %b actual %b",
							$time, exp_sym.run_last, m_tuser);
						err_cnt++;
					end
					if (m_tlast !== exp_sym.str_end) begin
						$display("%0t string_end mismatch: expected %b actual %b",
							$time, exp_sym.str_end, m_tlast);
						err_cnt++;
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		// simple escapes, mode dropped on the letter
		add_beat(CH_BSL, 1'b0, 1'b1);
		add_beat(CH_N, 1'b0, 1'b0);
		add_beat(CH_BSL, 1'b0, 1'b1);
		add_beat(CH_V, 1'b0, 1'b1);
		// bad hex digit breaks on a backslash, then oversized \U
		add_beat(CH_BSL, 1'b0, 1'b1);
		add_beat(CH_X, 1'b0, 1'b1);
		add_beat(8'h34, 1'b0, 1'b0);
		add_beat(CH_BSL, 1'b0, 1'b1);
		add_beat(CH_UU, 1'b0, 1'b1);
		repeat (4) add_beat(CH_UF, 1'b0, 1'b1);
		repeat (3) add_beat(CH_LF, 1'b0, 1'b1);
		add_beat(CH_LF, 1'b1, 1'b1);
		// string ends inside the digits
		add_beat(CH_BSL, 1'b0, 1'b1);
		add_beat(CH_LU, 1'b0, 1'b1);
		add_beat(8'h31, 1'b1, 1'b1);
		// hex letter as final byte
		add_beat(CH_BSL, 1'b0, 1'b1);
		add_beat(CH_LU, 1'b1, 1'b1);
		// trailing backslash
		add_beat(CH_BSL, 1'b1, 1'b1);
		// raw extremes
		add_beat(8'h00, 1'b0, 1'b0);
		add_beat(8'hFF, 1'b1, 1'b0);

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (feed_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
			@(posedge clk);

		rand_beats = 0;
		while (rand_beats < RAND_BEATS)
			add_string();

		while (feed_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
src/sed_pkg.sv
src/sed_front.sv
src/sed_fifo.sv
src/sed_back.sv
src/string_escape_decoder_core.sv
sim/string_escape_decoder_core_tb.sv
